// File: hdl/bmt_pkg.sv
// Shared types and constants for the breakpoint match table.
`timescale 1ns / 1ps

package bmt_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int ADDR_W         = 24;
  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 32;
  localparam int IDX_FIELD_W    = 3;
  localparam int OPCODE_W       = 3;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam int IN_FIELDS_W  = ADDR_W + IDX_FIELD_W + 1 + 1 + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + IDX_FIELD_W + 1 + ADDR_W + 1 + TIME_W + COUNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET      = 3'd0,
    OP_DELETE   = 3'd1,
    OP_ENABLE   = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_RETARGET = 3'd4,
    OP_QUERY    = 3'd5,
    OP_HIT      = 3'd6,
    OP_READ     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC,
    ST_FINISH,
    ST_DONE
  } st_t;

  // Decoded command as it travels from the front end to the execution unit.
  typedef struct packed {
    op_t                    op;
    logic [ADDR_W-1:0]      address;
    logic [IDX_FIELD_W-1:0] slot_index;
    logic                   idx_ok;
    logic                   enable_flag;
    logic                   match_any;
    logic [TIME_W-1:0]      now_time;
  } cmd_t;

endpackage

// File: hdl/bmt_front.sv
// Front end: accepts command transfers, decodes them and pushes them into the queue.
`timescale 1ns / 1ps

module bmt_front #(
  parameter int SLOT_COUNT = bmt_pkg::SLOT_COUNT_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: address[23:0], slot_index[26:24], enable_flag[27], match_any[28],
  //          now_time[60:29], zero pad above
  input  logic [bmt_pkg::IN_TDATA_W-1:0] s_tdata,
  // s_tuser: opcode[2:0]
  input  logic [bmt_pkg::OPCODE_W-1:0]   s_tuser,
  input  logic                           fifo_full,
  output logic                           push,
  output bmt_pkg::cmd_t                  push_cmd
);

  localparam int AW = bmt_pkg::ADDR_W;
  localparam int XW = bmt_pkg::IDX_FIELD_W;
  localparam int TW = bmt_pkg::TIME_W;
  localparam logic [XW:0] SlotLimit = (SLOT_COUNT > (1 << XW)) ? (XW+1)'(1 << XW)
                                                               : (XW+1)'(SLOT_COUNT);

  logic [XW-1:0] slot_index;

  assign s_tready = !fifo_full;
  assign push     = s_tvalid && !fifo_full;

  assign slot_index = s_tdata[AW +: XW];

  always_comb begin
    push_cmd.op          = bmt_pkg::op_t'(s_tuser);
    push_cmd.address     = s_tdata[AW-1:0];
    push_cmd.slot_index  = slot_index;
    // slots past the table size are silently ignored by the per-index operations
    push_cmd.idx_ok      = {1'b0, slot_index} < SlotLimit;
    push_cmd.enable_flag = s_tdata[AW + XW];
    push_cmd.match_any   = s_tdata[AW + XW + 1];
    push_cmd.now_time    = s_tdata[AW + XW + 2 +: TW];
  end

endmodule

// File: hdl/bmt_cmd_fifo.sv
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps

module bmt_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bmt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output bmt_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int Depth = bmt_pkg::CMD_FIFO_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW:0] DepthCnt = (PtrW+1)'(Depth);

  bmt_pkg::cmd_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full    = (count == DepthCnt);
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DepthCnt)
    else $error("command queue count out of range");

endmodule

// File: hdl/bmt_back.sv
// Execution unit: slot table, match logic, hit stamp memory and result register.
`timescale 1ns / 1ps

module bmt_back #(
  parameter int SLOT_COUNT = bmt_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fifo_empty,
  input  bmt_pkg::cmd_t                   fifo_cmd,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bmt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW   = bmt_pkg::ADDR_W;
  localparam int TW   = bmt_pkg::TIME_W;
  localparam int CW   = bmt_pkg::COUNT_W;
  localparam int XW   = bmt_pkg::IDX_FIELD_W;
  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PadW = bmt_pkg::OUT_TDATA_W - bmt_pkg::OUT_FIELDS_W;

  bmt_pkg::st_t  st;
  bmt_pkg::st_t  st_next;
  bmt_pkg::cmd_t cmd;

  // slot table
  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] en;
  logic [AW-1:0]         addr_tab [SLOT_COUNT];
  logic                  check_flag;

  // hit time and count memory; an entry without its stamp bit reads as zero
  logic [TW+CW-1:0]      stamp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] stamp_valid;
  logic [TW+CW-1:0]      rd_data;
  logic                  rd_valid;
  logic [IdxW-1:0]       rd_addr;

  // match results, registered at the end of the match step
  logic [SLOT_COUNT-1:0] hit_any;
  logic [SLOT_COUNT-1:0] hit_en;
  logic                  any_found_c, en_found_c, free_found_c;
  logic [IdxW-1:0]       any_slot_c, en_slot_c, free_slot_c;
  logic                  any_found, en_found, free_found;
  logic [IdxW-1:0]       any_slot, en_slot, free_slot;

  logic [IdxW-1:0] idx;
  logic            out_free;
  logic            load_out;
  logic            res_found;
  logic [IdxW-1:0] res_slot;
  logic [CW-1:0]   cur_count;
  logic [TW-1:0]   rb_time;
  logic [CW-1:0]   rb_count;
  logic [bmt_pkg::OUT_FIELDS_W-1:0] result;

  assign idx       = IdxW'(cmd.slot_index);
  assign out_free  = !m_tvalid || m_tready;
  assign cur_count = rd_valid ? rd_data[CW-1:0] : '0;
  assign rb_time   = rd_valid ? rd_data[CW +: TW] : '0;
  assign rb_count  = cur_count;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_any[i] = used[i] && (addr_tab[i] == cmd.address);
    end
    hit_en = hit_any & en;
  end

  // lowest index wins: scan from the top so the last assignment is the first match
  always_comb begin
    any_found_c  = 1'b0;
    en_found_c   = 1'b0;
    free_found_c = 1'b0;
    any_slot_c   = '0;
    en_slot_c    = '0;
    free_slot_c  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_any[i]) begin
        any_found_c = 1'b1;
        any_slot_c  = IdxW'(i);
      end
      if (hit_en[i]) begin
        en_found_c = 1'b1;
        en_slot_c  = IdxW'(i);
      end
      if (!used[i]) begin
        free_found_c = 1'b1;
        free_slot_c  = IdxW'(i);
      end
    end
  end

  // sequencer: next state
  always_comb begin
    st_next = st;
    unique case (st)
      bmt_pkg::ST_IDLE:   st_next = fifo_empty ? bmt_pkg::ST_IDLE : bmt_pkg::ST_MATCH;
      bmt_pkg::ST_MATCH:  st_next = bmt_pkg::ST_EXEC;
      bmt_pkg::ST_EXEC:   st_next = bmt_pkg::ST_FINISH;
      bmt_pkg::ST_FINISH: st_next = bmt_pkg::ST_DONE;
      bmt_pkg::ST_DONE: begin
        if (out_free) begin
          st_next = fifo_empty ? bmt_pkg::ST_IDLE : bmt_pkg::ST_MATCH;
        end
      end
      default:            st_next = bmt_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (st)
      bmt_pkg::ST_IDLE: pop = !fifo_empty;
      bmt_pkg::ST_DONE: begin
        load_out = out_free;
        pop      = out_free && !fifo_empty;
      end
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign rd_addr = (cmd.op == bmt_pkg::OP_HIT) ? any_slot : idx;

  always_comb begin
    res_found = 1'b0;
    res_slot  = '0;
    case (cmd.op)
      bmt_pkg::OP_QUERY: begin
        res_found = check_flag && (cmd.match_any ? any_found : en_found);
        res_slot  = cmd.match_any ? any_slot : en_slot;
      end
      bmt_pkg::OP_HIT: begin
        res_found = check_flag && en_found;
        res_slot  = any_slot;
      end
      default: begin
        res_found = 1'b0;
        res_slot  = '0;
      end
    endcase
    if (!res_found) begin
      res_slot = '0;
    end
  end

  always_comb begin
    result = '0;
    result[0]        = res_found;
    result[1 +: XW]  = XW'(res_slot);
    if (cmd.op == bmt_pkg::OP_READ && cmd.idx_ok) begin
      result[XW + 1]                   = used[idx];
      result[XW + 2 +: AW]             = addr_tab[idx];
      result[XW + AW + 2]              = en[idx];
      result[XW + AW + 3 +: TW]        = rb_time;
      result[XW + AW + TW + 3 +: CW]   = rb_count;
    end
    result[bmt_pkg::OUT_FIELDS_W-1] = check_flag;
  end

  // stamp memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (st == bmt_pkg::ST_EXEC) begin
      rd_data <= stamp_mem[rd_addr];
    end
    if (st == bmt_pkg::ST_FINISH && cmd.op == bmt_pkg::OP_HIT && check_flag && en_found) begin
      stamp_mem[any_slot] <= {cmd.now_time, cur_count + 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= fifo_cmd;
    end
    if (st == bmt_pkg::ST_MATCH) begin
      any_found  <= any_found_c;
      en_found   <= en_found_c;
      free_found <= free_found_c;
      any_slot   <= any_slot_c;
      en_slot    <= en_slot_c;
      free_slot  <= free_slot_c;
    end
    if (load_out) begin
      m_tdata <= {{PadW{1'b0}}, result};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= bmt_pkg::ST_IDLE;
      used        <= '0;
      en          <= '0;
      stamp_valid <= '0;
      rd_valid    <= 1'b0;
      check_flag  <= 1'b0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        addr_tab[i] <= '0;
      end
    end else begin
      st <= st_next;
      if (st == bmt_pkg::ST_EXEC) begin
        rd_valid <= stamp_valid[rd_addr];
        case (cmd.op)
          bmt_pkg::OP_SET: begin
            if (any_found) begin
              en[any_slot] <= cmd.enable_flag;
            end else if (free_found) begin
              used[free_slot]        <= 1'b1;
              addr_tab[free_slot]    <= cmd.address;
              en[free_slot]          <= cmd.enable_flag;
              stamp_valid[free_slot] <= 1'b0;
            end
          end
          bmt_pkg::OP_DELETE: begin
            if (any_found) begin
              used[any_slot] <= 1'b0;
            end
          end
          bmt_pkg::OP_ENABLE: begin
            if (cmd.idx_ok) begin
              en[idx] <= cmd.enable_flag;
            end
          end
          bmt_pkg::OP_CLEAR: begin
            if (cmd.idx_ok) begin
              stamp_valid[idx] <= 1'b0;
            end
          end
          bmt_pkg::OP_RETARGET: begin
            if (cmd.idx_ok) begin
              addr_tab[idx] <= cmd.address;
            end
          end
          default: begin
          end
        endcase
      end
      if (st == bmt_pkg::ST_FINISH) begin
        if (cmd.op == bmt_pkg::OP_SET || cmd.op == bmt_pkg::OP_DELETE) begin
          check_flag <= |(used & en);
        end
        if (cmd.op == bmt_pkg::OP_HIT && check_flag && en_found) begin
          stamp_valid[any_slot] <= 1'b1;
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(st) == bmt_pkg::ST_DONE)
    else $error("result register loaded outside the deliver step");
  a_check_flag_src: assert property (@(posedge clk) disable iff (rst)
      (check_flag != $past(check_flag)) |->
        ($past(st) == bmt_pkg::ST_FINISH &&
         ($past(cmd.op) == bmt_pkg::OP_SET || $past(cmd.op) == bmt_pkg::OP_DELETE)))
    else $error("check flag changed by an operation other than set or delete");
  a_pop_starts_match: assert property (@(posedge clk) disable iff (rst)
      pop |=> st == bmt_pkg::ST_MATCH)
    else $error("dequeued command did not enter the match step");
  a_found_needs_flag: assert property (@(posedge clk) disable iff (rst)
      load_out && res_found |-> check_flag)
    else $error("match reported while checking is inactive");

endmodule

// File: hdl/breakpoint_match_table_unit.sv
// Breakpoint match table top level: front end, command queue and execution unit.
`timescale 1ns / 1ps

// Keeps SLOT_COUNT breakpoint slots (address, enable, last hit time, wrapping hit
// count) and answers one result transfer per command transfer, in order. A command
// passes through the match, execute, finish and deliver steps in the execution
// unit, a hit reading its stamp in the execute step and writing it back in the finish
// step. The next command leaves the queue only once the current result can be loaded.
// A two-entry queue takes up to two more command transfers while a result waits on
// m_tready; after that s_tready drops until the result is taken.
// There is no clearing pass after reset: the table is usable in the first cycle.

module breakpoint_match_table_unit #(
  parameter int SLOT_COUNT = bmt_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: address[23:0], slot_index[26:24], enable_flag[27], match_any[28],
  //          now_time[60:29], zero pad [63:61]
  input  logic [bmt_pkg::IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: opcode[2:0]
  input  logic [bmt_pkg::OPCODE_W-1:0]    s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: found[0], match_slot[3:1], slot_used[4], slot_address[28:5],
  //          slot_enabled[29], slot_time[61:30], slot_count[93:62],
  //          check_active[94], zero pad [95]
  output logic [bmt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic          fifo_full;
  logic          fifo_empty;
  logic          push;
  logic          pop;
  bmt_pkg::cmd_t push_cmd;
  bmt_pkg::cmd_t pop_cmd;

  bmt_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .fifo_full(fifo_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bmt_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (fifo_full),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .empty   (fifo_empty)
  );

  bmt_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_empty(fifo_empty),
    .fifo_cmd  (pop_cmd),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
